// ===== rtl/peuu_pkg.sv =====
package peuu_pkg;

    localparam int ENTRY_W = 64;
    localparam int PROPS_W = 12;
    localparam int LEVEL_W = 3;
    localparam int FRAME_W = 40;
    localparam int STS_W   = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 40;

    // Entry bit positions.
    localparam int E_P     = 0;
    localparam int E_W     = 1;
    localparam int E_PWT   = 3;
    localparam int E_PCD   = 4;
    localparam int E_PAT   = 7;
    localparam int E_INUSE = 9;
    localparam int E_CHAIN = 10;
    localparam int E_LIMIT = 11;
    localparam int E_FLO   = 12;
    localparam int E_FHI   = 51;
    localparam int E_XD    = 63;

    // Property vector bit positions.
    localparam int P_R        = 0;
    localparam int P_W        = 1;
    localparam int P_X        = 2;
    localparam int P_INUSE    = 3;
    localparam int P_CHAINED  = 4;
    localparam int P_LIMIT    = 5;
    localparam int P_COMPLETE = 6;
    localparam int P_FRAME    = 7;
    localparam int P_DEFTABLE = 8;
    localparam int P_PWT      = 9;
    localparam int P_PCD      = 10;
    localparam int P_PAT      = 11;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_PAGING_LEVELS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_XD_ENABLED    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_L1TF_MASK     = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVELS_RESET = 3'd4;

    // Update status codes.
    localparam logic [STS_W-1:0] STS_OK          = 2'd0;
    localparam logic [STS_W-1:0] STS_HAS_FRAME   = 2'd1;
    localparam logic [STS_W-1:0] STS_CLEAR_UNSUP = 2'd2;

    typedef struct packed {
        logic [ENTRY_W-1:0] old_entry;
        logic [PROPS_W-1:0] set_props;
        logic [PROPS_W-1:0] clear_props;
        logic [LEVEL_W-1:0] table_level;
        logic               first_in_range;
        logic               last_in_range;
        logic [FRAME_W-1:0] target_frame;
    } t_in_item;

    typedef struct packed {
        logic [ENTRY_W-1:0] new_entry;
        logic               entry_written;
        logic [STS_W-1:0]   update_status;
    } t_out_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] paging_levels;
        logic               xd_enabled;
        logic [FRAME_W-1:0] l1tf_frame_mask;
    } t_cfg;

endpackage

// ===== rtl/peuu_cfg.sv =====
module peuu_cfg
    import peuu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CDATA_W-1:0] i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.paging_levels   <= LEVELS_RESET;
            r_cfg.xd_enabled      <= 1'b0;
            r_cfg.l1tf_frame_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAGING_LEVELS: r_cfg.paging_levels <= i_cfg_data[LEVEL_W-1:0];
                CFG_XD_ENABLED:    r_cfg.xd_enabled <= i_cfg_data[0];
                CFG_L1TF_MASK:     r_cfg.l1tf_frame_mask <= i_cfg_data[FRAME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/peuu_calc.sv =====
module peuu_calc
    import peuu_pkg::*;
(
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    logic [ENTRY_W-1:0] old;
    logic [PROPS_W-1:0] sp;
    logic [PROPS_W-1:0] cp;
    logic [ENTRY_W-1:0] base;
    logic [ENTRY_W-1:0] leaf_e;
    logic [FRAME_W-1:0] leaf_frame;
    logic               leaf;
    logic               present;
    logic               old_has_frame;

    assign old = i_item.old_entry;
    assign sp  = i_item.set_props;
    assign cp  = i_item.clear_props;

    assign leaf = ({1'b0, i_item.table_level} + 4'd1) == {1'b0, i_cfg.paging_levels};
    assign old_has_frame = |old[E_FHI:E_FLO];
    assign present = sp[P_R] | sp[P_W] | sp[P_X] | (~cp[P_R] & old[E_P]);

    // Common part: default-table bits, then frame install or clear.
    always_comb begin
        base = old;
        if (sp[P_DEFTABLE]) begin
            base[E_P] = 1'b1;
            base[E_W] = 1'b1;
        end
        if (sp[P_FRAME] | cp[P_FRAME]) begin
            base[E_FHI:E_FLO] = cp[P_FRAME] ? '0 : i_item.target_frame;
        end
    end

    always_comb begin
        leaf_e = base;
        leaf_e[E_P] = present;
        if (sp[P_W] | cp[P_W]) leaf_e[E_W] = sp[P_W];
        if (sp[P_X] | cp[P_X]) leaf_e[E_XD] = i_cfg.xd_enabled & cp[P_X];
        if (sp[P_INUSE] | cp[P_INUSE]) leaf_e[E_INUSE] = sp[P_INUSE];
        if (sp[P_COMPLETE]) begin
            leaf_e[E_CHAIN] = ~i_item.last_in_range;
            leaf_e[E_LIMIT] = i_item.last_in_range | i_item.first_in_range;
        end else begin
            if (sp[P_CHAINED] | cp[P_CHAINED]) leaf_e[E_CHAIN] = sp[P_CHAINED];
            if (sp[P_LIMIT] | cp[P_LIMIT]) leaf_e[E_LIMIT] = sp[P_LIMIT];
        end
        if (sp[P_PAT] | cp[P_PAT]) leaf_e[E_PAT] = sp[P_PAT];
        if (sp[P_PWT] | cp[P_PWT]) leaf_e[E_PWT] = sp[P_PWT];
        if (sp[P_PCD] | cp[P_PCD]) leaf_e[E_PCD] = sp[P_PCD];

        // L1TF: a present entry loses the high frame bits, a non-present one
        // that still points somewhere gets them forced on.
        leaf_frame = base[E_FHI:E_FLO];
        if (present) begin
            leaf_frame = leaf_frame & ~i_cfg.l1tf_frame_mask;
        end else if (|leaf_frame) begin
            leaf_frame = leaf_frame | i_cfg.l1tf_frame_mask;
        end
        leaf_e[E_FHI:E_FLO] = leaf_frame;
    end

    always_comb begin
        o_item.new_entry     = old;
        o_item.entry_written = 1'b0;
        o_item.update_status = STS_OK;
        if (leaf) begin
            o_item.new_entry     = leaf_e;
            o_item.entry_written = 1'b1;
        end else if (sp[P_FRAME] && old_has_frame) begin
            o_item.update_status = STS_HAS_FRAME;
        end else begin
            if (sp[P_FRAME]) begin
                o_item.new_entry     = base;
                o_item.entry_written = 1'b1;
            end
            if (cp[P_FRAME]) o_item.update_status = STS_CLEAR_UNSUP;
        end
    end

endmodule

// ===== rtl/page_entry_update_unit_core.sv =====
// Page table entry update unit. One entry update per transfer: the unit
// registers the item, computes the new entry in one pass of bit-field logic
// and holds the result in an output register; an item passes the input
// register, then the output register. A new item is taken in every cycle while
// the output side keeps up; a stalled output holds both stages. Configuration
// writes take effect at once and should only be made while the unit is empty.
module page_entry_update_unit_core
    import peuu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CDATA_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item
);

    t_cfg      cfg;
    t_out_item calc_item;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out_item;
    logic      r_out_valid;
    logic      out_adv;
    logic      in_adv;

    peuu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    peuu_calc u_calc (
        .i_cfg  (cfg),
        .i_item (r_in_item),
        .o_item (calc_item)
    );

    assign out_adv    = ~r_out_valid | ~i_out_stall;
    assign in_adv     = ~r_in_valid | out_adv;
    assign o_in_stall = ~in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) r_in_valid <= i_in_valid;
            if (out_adv) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) r_in_item <= i_in_item;
        if (out_adv && r_in_valid) r_out_item <= calc_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/peuu_checker.sv =====
module peuu_checker
    import peuu_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input t_out_item          o_out_item
);

    // A held result keeps its payload until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // The input only stalls behind a result that is itself held off.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    // A refused frame install never writes the entry.
    a_refuse_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.entry_written |->
            o_out_item.update_status != STS_HAS_FRAME)
        else $error("entry written with frame-present status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.update_status == STS_OK ||
            o_out_item.update_status == STS_HAS_FRAME ||
            o_out_item.update_status == STS_CLEAR_UNSUP)
        else $error("undefined update status");

endmodule

bind page_entry_update_unit_core peuu_checker u_peuu_checker (.*);
